### design/cawall_pkg.sv
package cawall_pkg;

    localparam int MAX_ROW_LENGTH  = 1024;
    localparam int ROW_COUNT_LIMIT = 4096;

    localparam int ROW_LENGTH_W = 11;
    localparam int ROW_COUNT_W  = 13;
    localparam int THRESH_W     = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;

    // Column index into the line stores, and a length that can hold MAX_ROW_LENGTH itself.
    localparam int COL_W     = $clog2(MAX_ROW_LENGTH);
    localparam int EFF_LEN_W = $clog2(MAX_ROW_LENGTH + 1);

    // The row counter runs one row past the frame to drain the last row.
    localparam int ROW_W = ROW_COUNT_W;

    localparam int WIN_BITS = 9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_LENGTH = 2'd0,
        REG_ROW_COUNT  = 2'd1,
        REG_SURVIVE    = 2'd2,
        REG_BIRTH      = 2'd3
    } cfg_reg_t;

    localparam logic ACT_CELL  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic left_ok;
        logic right_ok;
        logic top_ok;
        logic bot_ok;
    } edge_mask_t;

    typedef struct packed {
        logic upper;
        logic middle;
    } line_pair_t;

endpackage

### design/cawall_if.sv
interface cawall_in_if;
    logic valid;
    logic ready;
    logic action;
    logic cell_wall;

    modport source (output valid, output action, output cell_wall, input ready);
    modport sink (input valid, input action, input cell_wall, output ready);
endinterface

interface cawall_out_if;
    logic valid;
    logic ready;
    logic out_wall;
    logic out_last;

    modport source (output valid, output out_wall, output out_last, input ready);
    modport sink (input valid, input out_wall, input out_last, output ready);
endinterface

### design/cellular_automaton_wall_smoothing_top.sv
// Channel   | Dir | Payload               | Handshake
// ----------+-----+-----------------------+------------
// cell_in   | in  | action, cell_wall     | valid/ready
// cell_out  | out | out_wall, out_last    | valid/ready
// cfg       | in  | cfg_index, cfg_data   | cfg_write
//
// Unless stalled, one request is taken per cycle; any result is registered in the next cycle.
// Results trail the request stream by one row plus one cell, set by the two line stores.
// The line stores sit in one 2-bit wide RAM whose read is prefetched one request ahead.
// Reset clears counters and window at once; line store entries are masked until written.
// A request is taken while the output register is empty or being emptied in the same cycle.
module cellular_automaton_wall_smoothing_top
    import cawall_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    cawall_in_if.sink              cell_in,
    cawall_out_if.source           cell_out,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [EFF_LEN_W-1:0] eff_len_reg, eff_len_next;
    logic [ROW_W-1:0]     eff_cnt_reg, eff_cnt_next;
    logic [THRESH_W-1:0]  survive_reg, survive_next;
    logic [THRESH_W-1:0]  birth_reg, birth_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [WIN_BITS-1:0]  window_reg, window_next;
    logic                 fwd_reg, fwd_next;
    line_pair_t           fwd_data_reg, fwd_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_wall_reg, out_wall_next;
    logic                 out_last_reg, out_last_next;

    logic                 accept;
    logic                 geom_write;
    logic                 cell_v;
    line_pair_t           ram_rdata;
    line_pair_t           line_q;
    line_pair_t           line_wdata;
    logic [COL_W-1:0]     ram_raddr;
    logic [WIN_BITS-1:0]  window_shift;
    logic [WIN_BITS-1:0]  rule_win;
    edge_mask_t           rule_mask;
    logic                 rule_wall;
    logic                 col_zero;
    logic                 emit_row_end;
    logic                 emit_inner;
    logic                 emit;
    logic                 frame_last;
    logic [EFF_LEN_W-1:0] col_inc;
    logic [ROW_W-1:0]     cnt_plus_one;

    assign cell_in.ready   = !out_valid_reg || cell_out.ready;
    assign accept          = cell_in.valid && cell_in.ready;
    assign cell_out.valid  = out_valid_reg;
    assign cell_out.out_wall = out_wall_reg;
    assign cell_out.out_last = out_last_reg;

    assign geom_write = cfg_write
                        && (cfg_reg_t'(cfg_index) == REG_ROW_LENGTH
                            || cfg_reg_t'(cfg_index) == REG_ROW_COUNT);

    // Configuration registers; geometry is clamped to its legal range as it is written.
    always_comb
    begin
        logic [ROW_LENGTH_W-1:0] len_raw;
        logic [ROW_COUNT_W-1:0]  cnt_raw;
        len_raw      = cfg_data[ROW_LENGTH_W-1:0];
        cnt_raw      = cfg_data[ROW_COUNT_W-1:0];
        eff_len_next = eff_len_reg;
        eff_cnt_next = eff_cnt_reg;
        survive_next = survive_reg;
        birth_next   = birth_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW_LENGTH:
                begin
                    if (len_raw == '0)
                        eff_len_next = EFF_LEN_W'(1);
                    else if (32'(len_raw) > 32'(MAX_ROW_LENGTH))
                        eff_len_next = EFF_LEN_W'(MAX_ROW_LENGTH);
                    else
                        eff_len_next = EFF_LEN_W'(len_raw);
                end
                REG_ROW_COUNT:
                begin
                    if (cnt_raw == '0)
                        eff_cnt_next = ROW_W'(1);
                    else if (32'(cnt_raw) > 32'(ROW_COUNT_LIMIT))
                        eff_cnt_next = ROW_W'(ROW_COUNT_LIMIT);
                    else
                        eff_cnt_next = ROW_W'(cnt_raw);
                end
                REG_SURVIVE:    survive_next = cfg_data[THRESH_W-1:0];
                REG_BIRTH:      birth_next   = cfg_data[THRESH_W-1:0];
                default:        ;
            endcase
        end
    end

    // The RAM output holds the line store entries for the current column; a write to the
    // same column in the previous cycle is forwarded around the RAM.
    assign line_q = fwd_reg ? fwd_data_reg : ram_rdata;

    assign cell_v = (cell_in.action == ACT_FLUSH || row_reg >= eff_cnt_reg)
                    ? 1'b1 : cell_in.cell_wall;

    assign window_shift = {cell_v, line_q.middle, line_q.upper, window_reg[8:3]};

    assign line_wdata.upper  = line_q.middle;
    assign line_wdata.middle = cell_v;

    assign col_zero     = (col_reg == '0);
    assign cnt_plus_one = eff_cnt_reg + ROW_W'(1);
    assign col_inc      = EFF_LEN_W'(col_reg) + EFF_LEN_W'(1);

    // At column zero the finished cell is the last one of the row two rows up, taken from the
    // window before it shifts; otherwise it is the center of the shifted window.
    assign emit_row_end = col_zero && (row_reg >= ROW_W'(2));
    assign emit_inner   = !col_zero && (row_reg >= ROW_W'(1)) && (row_reg <= eff_cnt_reg);
    assign emit         = emit_row_end || emit_inner;
    assign frame_last   = emit_row_end && (row_reg == cnt_plus_one);

    always_comb
    begin
        if (col_zero)
        begin
            rule_win            = {3'b000, window_reg[8:3]};
            rule_mask.left_ok   = (eff_len_reg >= EFF_LEN_W'(2));
            rule_mask.right_ok  = 1'b0;
            rule_mask.top_ok    = (row_reg >= ROW_W'(3));
            rule_mask.bot_ok    = (row_reg <= eff_cnt_reg);
        end
        else
        begin
            rule_win            = window_shift;
            rule_mask.left_ok   = (col_reg >= COL_W'(2));
            rule_mask.right_ok  = 1'b1;
            rule_mask.top_ok    = (row_reg >= ROW_W'(2));
            rule_mask.bot_ok    = (row_reg < eff_cnt_reg);
        end
    end

    cawall_rule u_rule (
        .win            (rule_win),
        .mask           (rule_mask),
        .survive_thresh (survive_reg),
        .birth_thresh   (birth_reg),
        .wall           (rule_wall)
    );

    // Position counters, window and output register.
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        window_next    = window_reg;
        out_valid_next = out_valid_reg;
        out_wall_next  = out_wall_reg;
        out_last_next  = out_last_reg;

        if (cell_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (geom_write)
        begin
            col_next    = '0;
            row_next    = '0;
            window_next = '0;
        end
        else if (accept)
        begin
            out_valid_next = emit;
            out_wall_next  = rule_wall;
            out_last_next  = frame_last;
            if (emit && frame_last)
            begin
                col_next    = '0;
                row_next    = '0;
                window_next = '0;
            end
            else
            begin
                window_next = window_shift;
                if (col_inc >= eff_len_reg)
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
        end
    end

    // Prefetch the entries for the column the next request will use.
    assign ram_raddr     = col_next;
    assign fwd_next      = accept && (col_reg == ram_raddr);
    assign fwd_data_next = line_wdata;

    cawall_ram #(
        .WIDTH ($bits(line_pair_t)),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (line_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_len_reg   <= EFF_LEN_W'(64);
            eff_cnt_reg   <= ROW_W'(64);
            survive_reg   <= THRESH_W'(3);
            birth_reg     <= THRESH_W'(4);
            col_reg       <= '0;
            row_reg       <= '0;
            window_reg    <= '0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eff_len_reg   <= eff_len_next;
            eff_cnt_reg   <= eff_cnt_next;
            survive_reg   <= survive_next;
            birth_reg     <= birth_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            window_reg    <= window_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= fwd_data_next;
        out_wall_reg <= out_wall_next;
        out_last_reg <= out_last_next;
    end

endmodule

### design/cawall_ram.sv
module cawall_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/cawall_rule.sv
module cawall_rule
    import cawall_pkg::*;
(
    input  logic [WIN_BITS-1:0] win,
    input  edge_mask_t          mask,
    input  logic [THRESH_W-1:0] survive_thresh,
    input  logic [THRESH_W-1:0] birth_thresh,
    output logic                wall
);

    logic [3:0] count;

    // Window bit (col*3 + row); col 0 is left, row 0 is top, bit 4 is the center.
    always_comb
    begin
        logic in_grid;
        count = '0;
        for (int col = 0; col < 3; col++)
        begin
            for (int row = 0; row < 3; row++)
            begin
                in_grid = 1'b1;
                if (col == 0 && !mask.left_ok)  in_grid = 1'b0;
                if (col == 2 && !mask.right_ok) in_grid = 1'b0;
                if (row == 0 && !mask.top_ok)   in_grid = 1'b0;
                if (row == 2 && !mask.bot_ok)   in_grid = 1'b0;
                if (!(col == 1 && row == 1))
                begin
                    count = count + 4'(in_grid ? win[col * 3 + row] : 1'b1);
                end
            end
        end
        if (win[4])
        begin
            wall = (count > survive_thresh);
        end
        else
        begin
            wall = (count > birth_thresh);
        end
    end

endmodule

### design/cawall_checker.sv
module cawall_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_wall,
    input logic out_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_wall) && $stable(out_last))
        else $error("result changed while stalled");

    // An empty output register must never hold back the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // A result only appears in the cycle after a request was taken.
    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without a request");

endmodule

bind cellular_automaton_wall_smoothing_top cawall_checker u_cawall_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cell_in.valid),
    .in_ready  (cell_in.ready),
    .out_valid (cell_out.valid),
    .out_ready (cell_out.ready),
    .out_wall  (cell_out.out_wall),
    .out_last  (cell_out.out_last)
);

### sim/cellular_automaton_wall_smoothing_top_test.sv
`timescale 1ns / 1ps

module cellular_automaton_wall_smoothing_top_test
    import cawall_pkg::*;
();

    localparam int IDLE_MAX      = 14;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 1110;
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic wall;
        logic last;
    } smoothed_cell_t;

    class wall_smoothing_board;
        bit upper_row[MAX_ROW_LENGTH];
        bit middle_row[MAX_ROW_LENGTH];
        bit [WIN_BITS-1:0] window;
        int col;
        int row;
        int emitted;
        bit [ROW_LENGTH_W-1:0] row_length;
        bit [ROW_COUNT_W-1:0] row_count;
        bit [THRESH_W-1:0] survive_limit;
        bit [THRESH_W-1:0] birth_limit;
        smoothed_cell_t expected_cells[int];
        int exp_head;
        int exp_tail;
        int failures;

        function new();
            row_length = 64;
            row_count = 64;
            survive_limit = 3;
            birth_limit = 4;
            failures = 0;
            exp_head = 0;
            exp_tail = 0;
            restart();
        endfunction

        function void restart();
            window = '0;
            col = 0;
            row = 0;
            emitted = 0;
        endfunction

        function int eff_length();
            if (row_length == 0)
                return 1;
            if (row_length > MAX_ROW_LENGTH)
                return MAX_ROW_LENGTH;
            return int'(row_length);
        endfunction

        function int eff_count();
            if (row_count == 0)
                return 1;
            if (row_count > ROW_COUNT_LIMIT)
                return ROW_COUNT_LIMIT;
            return int'(row_count);
        endfunction

        function int pending();
            return exp_tail - exp_head;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ROW_LENGTH:
                begin
                    row_length = val[ROW_LENGTH_W-1:0];
                    restart();
                end
                REG_ROW_COUNT:
                begin
                    row_count = val[ROW_COUNT_W-1:0];
                    restart();
                end
                REG_SURVIVE: survive_limit = val[THRESH_W-1:0];
                REG_BIRTH:   birth_limit = val[THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        // Window bit (column * 3 + row); column 0 is the left one, row 0 the top one.
        function bit smoothed(bit [WIN_BITS-1:0] win, bit left_ok, bit right_ok,
                              bit top_ok, bit bot_ok);
            int count;
            bit in_grid;
            count = 0;
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    if (c == 1 && r == 1)
                        continue;
                    in_grid = !((c == 0 && !left_ok) || (c == 2 && !right_ok) ||
                                (r == 0 && !top_ok) || (r == 2 && !bot_ok));
                    count += in_grid ? int'(win[c * 3 + r]) : 1;
                end
            end
            if (win[4])
                return count > int'(survive_limit);
            return count > int'(birth_limit);
        endfunction

        function void note_request(logic act, logic wall);
            int w;
            int h;
            int r;
            int c;
            int idx;
            bit v;
            bit up;
            bit mid;
            bit res;
            bit emit;
            smoothed_cell_t exp_res;
            w = eff_length();
            h = eff_count();
            r = row;
            c = col;
            idx = c % MAX_ROW_LENGTH;
            res = 1'b0;
            emit = 1'b0;
            v = (act == ACT_FLUSH || r >= h) ? 1'b1 : bit'(wall);
            up = upper_row[idx];
            mid = middle_row[idx];

            // At the start of a row the old window still holds the last cell of the
            // row before; its right column lies outside the grid.
            if (c == 0 && r >= 2)
            begin
                res = smoothed({3'b000, window[8:3]}, w >= 2, 1'b0, r >= 3, (r - 1) < h);
                emit = 1'b1;
            end

            window = {v, mid, up, window[8:3]};
            upper_row[idx] = mid;
            middle_row[idx] = v;

            if (c >= 1 && r >= 1 && (r - 1) < h)
            begin
                res = smoothed(window, c >= 2, 1'b1, r >= 2, r < h);
                emit = 1'b1;
            end

            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
            end
            col = c;
            row = r;

            if (!emit)
                return;
            exp_res.wall = res;
            if (emitted + 1 >= w * h)
            begin
                exp_res.last = 1'b1;
                restart();
            end
            else begin
                exp_res.last = 1'b0;
                emitted++;
            end
            expected_cells[exp_tail] = exp_res;
            exp_tail++;
        endfunction

        function void check_result(logic wall, logic last);
            smoothed_cell_t want;
            if (pending() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, actual out_wall=%b out_last=%b",
                             $time, wall, last);
                return;
            end
            want = expected_cells[exp_head];
            expected_cells.delete(exp_head);
            exp_head++;
            if (wall !== want.wall)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: out_wall mismatch: expected %b actual %b",
                             $time, want.wall, wall);
            end
            if (last !== want.last)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: out_last mismatch: expected %b actual %b",
                             $time, want.last, last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cawall_in_if cell_in();
    cawall_out_if cell_out();

    bit idle_on = 1'b1;
    bit hold_due = 1'b0;
    int requests_sent = 0;
    int item_limit = 0;
    wall_smoothing_board board = new();

    cellular_automaton_wall_smoothing_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_in  (cell_in),
        .cell_out (cell_out),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    // Offers one request and returns at the edge where it is taken; valid stays up
    // so that a following request with no gap goes out on the next cycle.
    task automatic send_request(input logic act, input logic wall);
        int gap;
        gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            cell_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_in.valid <= 1'b1;
        cell_in.action <= act;
        cell_in.cell_wall <= wall;
        @(posedge clk);
        while (!cell_in.ready)
            @(posedge clk);
        board.note_request(act, wall);
        requests_sent++;
    endtask

    task automatic wait_idle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic end_phase();
        cell_in.valid <= 1'b0;
        wait_idle();
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        board.set_register(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // One grid frame followed by the flush that drains its last row. A noisy frame
    // mixes in flushes inside the grid, cells after it and stray trailing requests.
    task automatic send_frame(input int density, input bit noisy);
        int w;
        int h;
        w = board.eff_length();
        h = board.eff_count();
        for (int i = 0; i < w * h; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_request(ACT_FLUSH, 1'($urandom_range(0, 1)));
            else
                send_request(ACT_CELL, $urandom_range(0, 99) < density);
        end
        for (int i = 0; i <= w; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_request(ACT_CELL, 1'($urandom_range(0, 1)));
            else
                send_request(ACT_FLUSH, 1'($urandom_range(0, 1)));
        end
        if (noisy && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6))
                send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_phase(input int phase_no);
        int frames;
        idle_on = ($urandom_range(0, 4) != 0);
        if (phase_no == 2)
        begin
            // A frame long enough for the receiver hold to back up the input side.
            write_reg(REG_ROW_LENGTH, 8);
            write_reg(REG_ROW_COUNT, 8);
            idle_on = 1'b1;
            hold_due = 1'b1;
        end
        else begin
            if ($urandom_range(0, 4) < 3)
                write_reg(REG_ROW_LENGTH, CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                          $urandom_range(11, 48) : $urandom_range(0, 10)));
            if ($urandom_range(0, 4) < 3)
                write_reg(REG_ROW_COUNT, CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                          $urandom_range(7, 12) : $urandom_range(0, 6)));
        end
        if ($urandom_range(0, 1) == 1)
            write_reg(REG_SURVIVE, CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 15) : $urandom_range(0, 8)));
        if ($urandom_range(0, 1) == 1)
            write_reg(REG_BIRTH, CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 15) : $urandom_range(0, 8)));
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++)
        begin
            if (f > 0 && requests_sent >= item_limit)
                break;
            send_frame($urandom_range(0, 100), $urandom_range(0, 3) == 0);
        end
        end_phase();
    endtask

    initial
    begin
        int stall;
        cell_out.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_due)
            begin
                hold_due = 1'b0;
                stall = HOLD_CYCLES;
            end
            else begin
                stall = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            end
            if (stall > 0)
            begin
                cell_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            cell_out.ready <= 1'b1;
            @(posedge clk);
            while (!cell_out.valid)
                @(posedge clk);
            board.check_result(cell_out.out_wall, cell_out.out_last);
        end
    end

    initial
    begin
        int phase_no;
        cell_in.valid <= 1'b0;
        cell_in.action <= ACT_CELL;
        cell_in.cell_wall <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_ROW_LENGTH;
        cfg_data <= '0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x2 grid with the thresholds left at their reset values.
        write_reg(REG_ROW_LENGTH, 3);
        write_reg(REG_ROW_COUNT, 2);
        send_request(ACT_CELL, 1'b1);
        send_request(ACT_CELL, 1'b0);
        // A flush inside the grid counts as a wall cell.
        send_request(ACT_FLUSH, 1'b0);
        send_request(ACT_CELL, 1'b1);
        send_request(ACT_CELL, 1'b1);
        send_request(ACT_CELL, 1'b0);
        send_request(ACT_FLUSH, 1'b1);
        // A cell after the grid is complete only drains, its value is dropped.
        send_request(ACT_CELL, 1'b1);
        send_request(ACT_FLUSH, 1'b0);
        send_request(ACT_FLUSH, 1'b1);
        end_phase();

        // Zero geometry is taken as a single cell; thresholds of 8 and up are never met.
        write_reg(REG_ROW_LENGTH, 0);
        write_reg(REG_ROW_COUNT, 0);
        write_reg(REG_SURVIVE, 8);
        write_reg(REG_BIRTH, 15);
        send_request(ACT_CELL, 1'b0);
        send_request(ACT_FLUSH, 1'b0);
        send_request(ACT_FLUSH, 1'b1);
        send_request(ACT_CELL, 1'b1);
        send_request(ACT_FLUSH, 1'b0);
        send_request(ACT_FLUSH, 1'b0);
        end_phase();
        write_reg(REG_SURVIVE, 0);
        write_reg(REG_BIRTH, 0);
        send_request(ACT_CELL, 1'b0);
        send_request(ACT_FLUSH, 1'b1);
        send_request(ACT_FLUSH, 1'b0);
        end_phase();

        // A geometry write in the middle of a frame starts a new one.
        write_reg(REG_ROW_LENGTH, 2);
        write_reg(REG_ROW_COUNT, 2);
        send_request(ACT_CELL, 1'b1);
        send_request(ACT_CELL, 1'b0);
        end_phase();
        write_reg(REG_ROW_LENGTH, 2);
        send_request(ACT_CELL, 1'b0);
        send_request(ACT_CELL, 1'b1);
        send_request(ACT_CELL, 1'b1);
        send_request(ACT_CELL, 1'b0);
        end_phase();
        // Threshold writes apply to the rest of the frame at once.
        write_reg(REG_SURVIVE, 8);
        write_reg(REG_BIRTH, 2);
        send_request(ACT_FLUSH, 1'b0);
        send_request(ACT_FLUSH, 1'b1);
        send_request(ACT_FLUSH, 1'b0);
        end_phase();

        phase_no = 0;
        item_limit = requests_sent + RANDOM_ITEMS;
        while (requests_sent < item_limit || phase_no <= 2)
        begin
            random_phase(phase_no);
            phase_no++;
        end

        if (board.failures == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### cellular_automaton_wall_smoothing_top.f
design/cawall_pkg.sv
design/cawall_if.sv
design/cawall_ram.sv
design/cawall_rule.sv
design/cellular_automaton_wall_smoothing_top.sv
design/cawall_checker.sv
sim/cellular_automaton_wall_smoothing_top_test.sv
